// File: rtl/pconv_pkg.sv
// shared constants and types of the 3x3 pixel convolution
package pconv_pkg;

	localparam int MaxWidth = 1024;
	localparam int Channels = 4;
	localparam int AddrW = $clog2(MaxWidth);
	localparam int PixW = 8 * Channels;
	localparam int ColW = 10;
	localparam int RowW = 12;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 24;
	localparam int AccW = 20;
	localparam int QuoW = 20;

	localparam logic [CfgIdxW-1:0] REG_MASK_TOP = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MASK_MID = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MASK_BOT = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_DIVISOR = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_WIDTH = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_HEIGHT = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_CHANNELS = 3'd6;

	typedef logic [PixW-1:0] pix_t;

	typedef struct packed {
		logic [ColW-1:0] col;
		logic [RowW-1:0] row;
		logic            last;
		logic [2:0]      chans;
	} tag_t;

endpackage

// File: rtl/pconv_ram.sv
// generic single-port-write ram with registered read
module pconv_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/pconv_div.sv
// sequential signed divider with truncation toward zero and clamp to 0..255
module pconv_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [pconv_pkg::AccW-1:0] dividend,
	input  logic [7:0]                        divisor,
	output logic                              done,
	output logic [7:0]                        result
);
	import pconv_pkg::*;

	logic [QuoW-1:0] rem_q;
	logic [QuoW-1:0] quo_q;
	logic [7:0]      dvs_q;
	logic            neg_q;
	logic [4:0]      cnt_q;
	logic            busy_q;
	logic [QuoW:0]   trial;
	logic [QuoW-1:0] mag;

	assign mag = dividend[AccW-1] ? QuoW'(-dividend) : QuoW'(dividend);
	assign trial = {rem_q, quo_q[QuoW-1]} - {{(QuoW-7){1'b0}}, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(QuoW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			dvs_q <= (divisor == 8'd0) ? 8'd1 : divisor;
			neg_q <= dividend[AccW-1];
		end else if (busy_q) begin
			if (!trial[QuoW]) begin
				rem_q <= trial[QuoW-1:0];
				quo_q <= {quo_q[QuoW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[QuoW-2:0], quo_q[QuoW-1]};
				quo_q <= {quo_q[QuoW-2:0], 1'b0};
			end
		end
	end

	assign result = (neg_q || quo_q == '0) ? 8'd0 :
		(quo_q > QuoW'(255)) ? 8'd255 : quo_q[7:0];
endmodule

// File: rtl/pixel_convolution_3x3.sv
// 3x3 pixel convolution over a raster stream, top level
// after an item is accepted, the line stores are read and the window is shifted; then, per
// channel, nine taps are multiply-accumulated and the sum is divided; results are registered
// one pixel at a time; a border pixel skips the arithmetic, and an interior pixel is paced by the
// single shared multiplier and the bit-serial divider; a held result stalls
// arst_n clears control, window and counters; line stores are undefined until written
module pixel_convolution_3x3 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [31:0]                         s_tdata,  // in_chan0..in_chan3
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [55:0]                         m_tdata,  // out_col, out_row, out_chan0..3, pad
	output logic                                m_tlast,  // frame_done
	input  logic                                cfg_we,
	input  logic [pconv_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [pconv_pkg::CfgDataW-1:0]      cfg_data
);
	import pconv_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_MAC = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_WAIT = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	logic [23:0] mask_q [3];
	logic [7:0]  divisor_q;
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [2:0]  chans_q;

	logic [2:0]      state_q;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	pix_t            pix_q;
	pix_t            win_q [9];
	tag_t            tag_q;
	logic [3:0]      tap_q;
	logic [1:0]      chan_q;
	logic signed [AccW-1:0] acc_q;
	logic [7:0]      res_q [Channels];
	logic [55:0]     out_q;
	logic            out_last_q;
	logic            out_valid_q;

	logic [AddrW-1:0] addr;
	pix_t             rd_a;
	pix_t             rd_b;
	logic             we;

	logic [11:0] w_eff;
	logic [12:0] h_eff;
	logic [2:0]  ch_eff;
	logic        emit;
	logic        col_wrap;
	logic        row_wrap;
	logic [7:0]  samp;
	logic signed [7:0] coefv;
	logic signed [16:0] prod;
	logic        div_start;
	logic        div_done;
	logic [7:0]  div_res;

	assign addr = col_q[AddrW-1:0];
	assign we = (state_q == ST_READ);

	pconv_ram #(.Width(PixW), .Depth(MaxWidth)) u_line_a (
		.clk(clk), .we(we), .waddr(addr), .wdata(pix_q), .raddr(addr), .rdata(rd_a)
	);
	pconv_ram #(.Width(PixW), .Depth(MaxWidth)) u_line_b (
		.clk(clk), .we(we), .waddr(addr), .wdata(rd_a), .raddr(addr), .rdata(rd_b)
	);

	always_comb begin
		w_eff = (width_q < 11'd3) ? 12'd3 :
			(width_q > 11'(MaxWidth)) ? 12'(MaxWidth) : {1'b0, width_q};
		h_eff = (height_q < 13'd3) ? 13'd3 :
			(height_q > 13'd4096) ? 13'd4096 : height_q;
		ch_eff = (chans_q == 3'd0) ? 3'd1 :
			(chans_q > 3'(Channels)) ? 3'(Channels) : chans_q;
		emit = (col_q >= ColW'(2)) && (row_q >= RowW'(2)) &&
			({2'b0, col_q} < w_eff) && ({1'b0, row_q} < h_eff);
		col_wrap = ({2'b0, col_q} + 12'd1 >= w_eff);
		row_wrap = ({1'b0, row_q} + 13'd1 >= h_eff);
	end

	always_comb begin
		samp = win_q[tap_q][chan_q*8 +: 8];
		coefv = '0;
		case (tap_q)
			4'd0, 4'd1, 4'd2: coefv = mask_q[0][{tap_q[1:0], 3'b000} +: 8];
			4'd3, 4'd4, 4'd5: coefv = mask_q[1][{2'(tap_q - 4'd3), 3'b000} +: 8];
			4'd6, 4'd7, 4'd8: coefv = mask_q[2][{2'(tap_q - 4'd6), 3'b000} +: 8];
			default: coefv = '0;
		endcase
		prod = $signed({1'b0, samp}) * coefv;
	end

	assign div_start = (state_q == ST_MAC) && (tap_q == 4'd9);

	pconv_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(acc_q),
		.divisor(divisor_q), .done(div_done), .result(div_res)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;
	assign m_tlast = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q[0] <= 24'h010101;
			mask_q[1] <= 24'h010101;
			mask_q[2] <= 24'h010101;
			divisor_q <= 8'd9;
			width_q <= 11'd1024;
			height_q <= 13'd768;
			chans_q <= 3'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MASK_TOP: mask_q[0] <= cfg_data;
				REG_MASK_MID: mask_q[1] <= cfg_data;
				REG_MASK_BOT: mask_q[2] <= cfg_data;
				REG_DIVISOR: divisor_q <= cfg_data[7:0];
				REG_WIDTH: width_q <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				REG_CHANNELS: chans_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
			tap_q <= '0;
			chan_q <= '0;
		end else begin
			if (m_tready && state_q != ST_OUT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						pix_q <= s_tdata;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_SHIFT;
				ST_SHIFT: begin
					for (int r = 0; r < 3; r++) begin
						win_q[r*3] <= win_q[r*3+1];
						win_q[r*3+1] <= win_q[r*3+2];
					end
					win_q[2] <= rd_b;
					win_q[5] <= rd_a;
					win_q[8] <= pix_q;
					tag_q.col <= col_q - ColW'(1);
					tag_q.row <= row_q - RowW'(1);
					tag_q.last <= ({2'b0, col_q} == w_eff - 12'd1) &&
						({1'b0, row_q} == h_eff - 13'd1);
					tag_q.chans <= ch_eff;
					tap_q <= '0;
					chan_q <= '0;
					acc_q <= '0;
					state_q <= emit ? ST_MAC : ST_IDLE;
					if (col_wrap) begin
						col_q <= '0;
						row_q <= row_wrap ? '0 : row_q + RowW'(1);
					end else begin
						col_q <= col_q + ColW'(1);
					end
				end
				ST_MAC: begin
					if (tap_q == 4'd9) begin
						state_q <= ST_DIV;
					end else begin
						acc_q <= acc_q + AccW'(prod);
						tap_q <= tap_q + 4'd1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						tap_q <= '0;
						acc_q <= '0;
						if ({1'b0, chan_q} + 3'd1 >= tag_q.chans) begin
							state_q <= ST_WAIT;
						end else begin
							chan_q <= chan_q + 2'd1;
							state_q <= ST_MAC;
						end
					end
				end
				ST_WAIT: begin
					if (!out_valid_q || m_tready) state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done) begin
			res_q[chan_q] <= div_res;
		end
		if (state_q == ST_OUT) begin
			out_q <= {2'b00,
				(tag_q.chans > 3'd3) ? res_q[3] : 8'd0,
				(tag_q.chans > 3'd2) ? res_q[2] : 8'd0,
				(tag_q.chans > 3'd1) ? res_q[1] : 8'd0,
				res_q[0], tag_q.row, tag_q.col};
			out_last_q <= tag_q.last;
		end
	end
endmodule
